### hw/rtl/dns_qname_label_encode_core_assert.svh
// Assertion macros shared by the checker of the DNS name label encoder.
// Relies on nothing else; the including file supplies clock and reset names.
`ifndef DNS_QNAME_LABEL_ENCODE_CORE_ASSERT_SVH
`define DNS_QNAME_LABEL_ENCODE_CORE_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define DQLE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dqle assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define DQLE_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("dqle assertion failed");

`endif

### hw/rtl/dqle_pkg.sv
// Package for the DNS name label encoder: constants, state codes and cell control type.
// Has no dependencies; every other file of the block but the assertion header imports it.
`default_nettype none

package dqle_pkg;

    localparam int LABEL_MAX = 62;
    localparam int CNT_W     = $clog2(LABEL_MAX + 1);
    localparam int CH_W      = 8;
    localparam logic [CH_W-1:0] DOT_CHAR = 8'h2E;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LEN  = 4'b0010,
        ST_CHR  = 4'b0100,
        ST_TERM = 4'b1000
    } t_state;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

`default_nettype wire

### hw/rtl/dqle_if.sv
// Valid/ready channel interfaces for the input characters and the encoded bytes.
// Depends on dqle_pkg for the character width.
`default_nettype none

interface dqle_in_if;
    import dqle_pkg::*;
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;
    logic            end_of_name;

    modport source (output valid, output ch, output end_of_name, input ready);
    modport sink   (input valid, input ch, input end_of_name, output ready);
endinterface

interface dqle_out_if;
    import dqle_pkg::*;
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] wire_byte;
    logic            last_of_run;
    logic            label_overflow;

    modport source (output valid, output wire_byte, output last_of_run,
                     output label_overflow, input ready);
    modport sink   (input valid, input wire_byte, input last_of_run,
                     input label_overflow, output ready);
endinterface

`default_nettype wire

### hw/rtl/dns_qname_label_encode_core.sv
// The first result of an item is offered in the cycle after its transfer.
// No new character is accepted until every result of the last one has been taken; the single
// emit sequencer sends a label's length byte, then its characters, then the terminator if any.
// Reset (synchronous, active low) clears the sequencer, label count and overflow flag;
// the character cells are not reset.
`default_nettype none

module dns_qname_label_encode_core
    import dqle_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    dqle_in_if.sink    i_in,
    dqle_out_if.source o_out
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ovf,   n_ovf;
    logic [CNT_W-1:0] r_len,   n_len;
    logic             r_len_ovf, n_len_ovf;
    logic             r_term,  n_term;

    logic             w_in_xfer;
    logic             w_out_xfer;
    logic             w_store;
    logic             w_shift;
    logic [CNT_W-1:0] w_cnt_inc;
    logic             w_ovf_new;

    t_cell_ctl        w_ctl  [LABEL_MAX];
    logic [CH_W-1:0]  w_cell [LABEL_MAX];

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign w_out_xfer = o_out.valid && o_out.ready;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_len     = r_len;
        n_len_ovf = r_len_ovf;
        n_term    = r_term;
        w_store   = 1'b0;
        w_shift   = 1'b0;
        w_cnt_inc = r_count;
        w_ovf_new = r_ovf;

        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    if (i_in.ch == DOT_CHAR) begin
                        n_len     = r_count;
                        n_len_ovf = r_ovf;
                        n_term    = i_in.end_of_name;
                        n_count   = '0;
                        n_ovf     = 1'b0;
                        n_state   = ST_LEN;
                    end else begin
                        // Characters past the limit are dropped and remembered.
                        if (r_count < CNT_W'(LABEL_MAX)) begin
                            w_store   = 1'b1;
                            w_cnt_inc = r_count + 1'b1;
                        end else begin
                            w_ovf_new = 1'b1;
                        end
                        if (i_in.end_of_name) begin
                            n_len     = w_cnt_inc;
                            n_len_ovf = w_ovf_new;
                            n_term    = 1'b1;
                            n_count   = '0;
                            n_ovf     = 1'b0;
                            n_state   = ST_LEN;
                        end else begin
                            n_count = w_cnt_inc;
                            n_ovf   = w_ovf_new;
                        end
                    end
                end
            end
            ST_LEN: begin
                if (w_out_xfer) begin
                    if (r_len != '0) begin
                        n_state = ST_CHR;
                    end else if (r_term) begin
                        n_state = ST_TERM;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_CHR: begin
                if (w_out_xfer) begin
                    w_shift = 1'b1;
                    n_len   = r_len - 1'b1;
                    if (r_len == CNT_W'(1)) begin
                        n_state = r_term ? ST_TERM : ST_IDLE;
                    end
                end
            end
            ST_TERM: begin
                if (w_out_xfer) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
        r_len     <= n_len;
        r_len_ovf <= n_len_ovf;
        r_term    <= n_term;
    end

    // The chain shifts towards cell zero, which always shows the next character to send.
    for (genvar g = 0; g < LABEL_MAX; g++) begin : g_cell
        assign w_ctl[g].load  = w_store && (r_count == CNT_W'(g));
        assign w_ctl[g].shift = w_shift;

        if (g == LABEL_MAX - 1) begin : g_tail
            dqle_cell u_cell (
                .i_clk     (i_clk),
                .i_ctl     (w_ctl[g]),
                .i_new_ch  (i_in.ch),
                .i_next_ch ({CH_W{1'b0}}),
                .o_ch      (w_cell[g])
            );
        end else begin : g_body
            dqle_cell u_cell (
                .i_clk     (i_clk),
                .i_ctl     (w_ctl[g]),
                .i_new_ch  (i_in.ch),
                .i_next_ch (w_cell[g+1]),
                .o_ch      (w_cell[g])
            );
        end
    end

    always_comb begin
        o_out.valid          = 1'b0;
        o_out.wire_byte      = '0;
        o_out.last_of_run    = 1'b0;
        o_out.label_overflow = 1'b0;
        case (r_state)
            ST_LEN: begin
                o_out.valid          = 1'b1;
                o_out.wire_byte      = {{(CH_W-CNT_W){1'b0}}, r_len};
                o_out.label_overflow = r_len_ovf;
                o_out.last_of_run    = (r_len == '0) && !r_term;
            end
            ST_CHR: begin
                o_out.valid       = 1'b1;
                o_out.wire_byte   = w_cell[0];
                o_out.last_of_run = (r_len == CNT_W'(1)) && !r_term;
            end
            ST_TERM: begin
                o_out.valid       = 1'b1;
                o_out.last_of_run = 1'b1;
            end
            default: begin
                o_out.valid = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/dqle_cell.sv
// One character cell of the label chain: loads a new character or takes its neighbour's.
// Depends on dqle_pkg for the control struct and character width.
`default_nettype none

module dqle_cell
    import dqle_pkg::*;
(
    input  wire             i_clk,
    input  wire t_cell_ctl  i_ctl,
    input  wire  [CH_W-1:0] i_new_ch,
    input  wire  [CH_W-1:0] i_next_ch,
    output logic [CH_W-1:0] o_ch
);

    logic [CH_W-1:0] r_data;
    logic [CH_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.load) begin
            n_data = i_new_ch;
        end else if (i_ctl.shift) begin
            n_data = i_next_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_ch = r_data;

endmodule

`default_nettype wire

### hw/rtl/dqle_chk.sv
// Port-level checker for the DNS name label encoder, bound to the top level.
// Depends on dqle_pkg and the assertion macros in dns_qname_label_encode_core_assert.svh.
`default_nettype none

`include "dns_qname_label_encode_core_assert.svh"

module dqle_chk
    import dqle_pkg::*;
(
    input wire            i_clk,
    input wire            i_rst_n,
    input wire            i_in_valid,
    input wire            i_in_ready,
    input wire [CH_W-1:0] i_in_ch,
    input wire            i_in_end,
    input wire            i_out_valid,
    input wire            i_out_ready,
    input wire [CH_W-1:0] i_out_byte,
    input wire            i_out_last,
    input wire            i_out_ovf
);

    logic            w_in_xfer;
    logic            w_out_stall;
    logic            w_dot_xfer;
    logic            w_quiet_xfer;
    logic            w_ovf_len_ok;
    logic [CH_W+1:0] w_out_word;

    assign w_in_xfer    = i_in_valid && i_in_ready;
    assign w_out_stall  = i_out_valid && !i_out_ready;
    assign w_dot_xfer   = w_in_xfer && (i_in_ch == DOT_CHAR);
    assign w_quiet_xfer = w_in_xfer && (i_in_ch != DOT_CHAR) && !i_in_end;
    assign w_ovf_len_ok = !(i_out_valid && i_out_ovf) || (i_out_byte == CH_W'(LABEL_MAX));
    assign w_out_word   = {i_out_byte, i_out_last, i_out_ovf};

    // A stalled result must hold until its transfer.
    `DQLE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall, i_out_valid && $stable(w_out_word))
    // No new character is taken while results are still pending.
    `DQLE_ASSERT(a_no_overlap, i_clk, i_rst_n, !(w_in_xfer && i_out_valid))
    // A dot always produces a length byte on the next cycle.
    `DQLE_ASSERT_NEXT(a_dot_emits, i_clk, i_rst_n, w_dot_xfer, i_out_valid)
    // A plain character that does not end the name produces nothing.
    `DQLE_ASSERT_NEXT(a_char_quiet, i_clk, i_rst_n, w_quiet_xfer, !i_out_valid)
    // A truncated label always reports the limit as its length.
    `DQLE_ASSERT(a_ovf_len, i_clk, i_rst_n, w_ovf_len_ok)

endmodule

bind dns_qname_label_encode_core dqle_chk u_dqle_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_ch     (i_in.ch),
    .i_in_end    (i_in.end_of_name),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.wire_byte),
    .i_out_last  (o_out.last_of_run),
    .i_out_ovf   (o_out.label_overflow)
);

`default_nettype wire

### tb/sv/tb_dns_qname_label_encode_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for the DNS name label encoder: directed rows, then random names and noise.
// Depends on dqle_pkg, the dqle_in_if and dqle_out_if channel interfaces and the core itself.

module tb_dns_qname_label_encode_core;
    import dqle_pkg::*;

    typedef struct packed {
        logic [CH_W-1:0] wire_byte;
        logic            last_of_run;
        logic            label_overflow;
    } t_encoded_byte;

    // One row of the directed part: a character repeated reps times (incrementing),
    // with end of name on the final repetition only. A typed first byte is checked on
    // the final repetition, which is the one that causes results.
    typedef struct {
        logic [CH_W-1:0] ch;
        bit              eon;
        int              reps;
        bit              typed;
        logic [CH_W-1:0] first_byte;
        bit              first_ovf;
    } t_stim_row;

    localparam int NUM_ROWS = 15;

    t_stim_row directed_rows [NUM_ROWS] = '{
        '{DOT_CHAR, 1'b0,  1, 1'b1, 8'd0,  1'b0},  // leading dot straight after reset
        '{DOT_CHAR, 1'b0,  1, 1'b1, 8'd0,  1'b0},  // two dots in a row
        '{8'h77,    1'b0,  3, 1'b0, 8'd0,  1'b0},
        '{DOT_CHAR, 1'b0,  1, 1'b1, 8'd3,  1'b0},
        '{8'h00,    1'b0,  1, 1'b0, 8'd0,  1'b0},
        '{8'hFF,    1'b0,  1, 1'b0, 8'd0,  1'b0},
        '{DOT_CHAR, 1'b0,  1, 1'b1, 8'd2,  1'b0},
        '{8'h63,    1'b1,  1, 1'b1, 8'd1,  1'b0},  // end of name on a character
        '{DOT_CHAR, 1'b1,  1, 1'b1, 8'd0,  1'b0},  // lone dot closing an empty name
        '{8'h78,    1'b0,  1, 1'b0, 8'd0,  1'b0},
        '{DOT_CHAR, 1'b1,  1, 1'b1, 8'd1,  1'b0},  // trailing dot
        '{8'h41,    1'b1, 63, 1'b1, 8'd62, 1'b1},  // overflow on the last label
        '{8'h2D,    1'b1,  1, 1'b1, 8'd1,  1'b0},
        '{8'h2F,    1'b0,  1, 1'b0, 8'd0,  1'b0},
        '{DOT_CHAR, 1'b0,  1, 1'b0, 8'd0,  1'b0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    dqle_in_if  in_ch ();
    dqle_out_if out_ch ();

    dns_qname_label_encode_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // Predictor state.
    logic [CH_W-1:0] held_chars [LABEL_MAX];
    int              held_count    = 0;
    bit              held_overflow = 1'b0;

    t_encoded_byte   run_bytes_q [$];
    t_encoded_byte   expected_bytes_q [$];

    int mismatches       = 0;
    int sender_idle_pct  = 0;
    int receiver_stall_pct = 0;
    int random_items     = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

    function automatic void flush_label();
        run_bytes_q.push_back('{CH_W'(held_count), 1'b0, held_overflow});
        for (int i = 0; i < held_count; i++)
            run_bytes_q.push_back('{held_chars[i], 1'b0, 1'b0});
        held_count    = 0;
        held_overflow = 1'b0;
    endfunction

    // Works out the bytes that one accepted character causes, into run_bytes_q.
    function automatic void encode_char(logic [CH_W-1:0] ch, bit eon);
        t_encoded_byte tail;
        run_bytes_q.delete();
        if (ch == DOT_CHAR) begin
            flush_label();
        end else if (held_count < LABEL_MAX) begin
            held_chars[held_count] = ch;
            held_count++;
        end else begin
            held_overflow = 1'b1;
        end
        if (eon) begin
            if (held_count > 0)
                flush_label();
            run_bytes_q.push_back('{'0, 1'b0, 1'b0});
            held_count    = 0;
            held_overflow = 1'b0;
        end
        if (run_bytes_q.size() > 0) begin
            tail = run_bytes_q[run_bytes_q.size()-1];
            tail.last_of_run = 1'b1;
            run_bytes_q[run_bytes_q.size()-1] = tail;
        end
    endfunction

    // Offers one character and, on its transfer, queues what it should produce.
    // Entered just after a falling edge; returns at a falling edge.
    task automatic send_char(logic [CH_W-1:0] ch, bit eon, bit typed = 1'b0,
                             logic [CH_W-1:0] first_byte = '0, bit first_ovf = 1'b0);
        t_encoded_byte head;
        while ($urandom_range(99) < sender_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.ch          <= ch;
        in_ch.end_of_name <= eon;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        encode_char(ch, eon);
        if (typed && run_bytes_q.size() > 0) begin
            head = run_bytes_q[0];
            head.wire_byte      = first_byte;
            head.label_overflow = first_ovf;
            run_bytes_q[0] = head;
        end
        foreach (run_bytes_q[i])
            expected_bytes_q.push_back(run_bytes_q[i]);
        random_items++;
        @(negedge i_clk);
    endtask

    function automatic logic [CH_W-1:0] label_char();
        logic [CH_W-1:0] c;
        if ($urandom_range(3) != 0)
            return CH_W'($urandom_range(8'h61, 8'h7A));
        c = CH_W'($urandom_range(255));
        return (c == DOT_CHAR) ? 8'h2D : c;
    endfunction

    // A well-formed name: a few labels, now and then an empty or an over-long one,
    // closed either on its last character or by a trailing dot.
    task automatic send_name();
        int  nlabels;
        int  len;
        bit  trailing;
        nlabels  = $urandom_range(1, 4);
        trailing = ($urandom_range(9) < 3);
        for (int l = 0; l < nlabels; l++) begin
            len = ($urandom_range(99) < 3) ? $urandom_range(55, 70) : $urandom_range(0, 9);
            if (l == nlabels - 1 && len == 0)
                trailing = 1'b1;
            for (int c = 0; c < len; c++)
                send_char(label_char(), (l == nlabels - 1) && (c == len - 1) && !trailing);
            if (l < nlabels - 1)
                send_char(DOT_CHAR, 1'b0);
        end
        if (trailing)
            send_char(DOT_CHAR, 1'b1);
    endtask

    task automatic send_noise();
        logic [CH_W-1:0] c;
        c = ($urandom_range(3) == 0) ? DOT_CHAR : CH_W'($urandom_range(255));
        send_char(c, $urandom_range(9) == 0);
    endtask

    task automatic drain();
        while (expected_bytes_q.size() != 0)
            @(negedge i_clk);
    endtask

    // Receiver: stalls at random according to the current phase.
    always @(negedge i_clk)
        out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);

    // Every transfer on the output is compared with the oldest expected byte.
    always @(posedge i_clk) begin
        t_encoded_byte want;
        t_encoded_byte got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.wire_byte, out_ch.last_of_run, out_ch.label_overflow};
            if (expected_bytes_q.size() == 0) begin
                $display("%0t: unexpected byte: got byte=%02h last=%b ovf=%b", $time,
                         got.wire_byte, got.last_of_run, got.label_overflow);
                mismatches++;
            end else begin
                want = expected_bytes_q.pop_front();
                if (got !== want) begin
                    $display("%0t: expected byte=%02h last=%b ovf=%b, got byte=%02h last=%b ovf=%b",
                             $time, want.wire_byte, want.last_of_run, want.label_overflow,
                             got.wire_byte, got.last_of_run, got.label_overflow);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        int idle_by_phase  [4];
        int stall_by_phase [4];
        idle_by_phase     = '{0, 67, 0, 23};
        stall_by_phase    = '{0, 0, 67, 23};
        in_ch.valid       <= 1'b0;
        in_ch.ch          <= '0;
        in_ch.end_of_name <= 1'b0;
        i_rst_n           <= 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r])
            for (int i = 0; i < directed_rows[r].reps; i++)
                send_char(directed_rows[r].ch + CH_W'(i),
                          directed_rows[r].eon && (i == directed_rows[r].reps - 1),
                          directed_rows[r].typed && (i == directed_rows[r].reps - 1),
                          directed_rows[r].first_byte, directed_rows[r].first_ovf);

        // The sender holds off here until the block has delivered everything.
        in_ch.valid <= 1'b0;
        drain();

        for (int p = 0; p < 4; p++) begin
            sender_idle_pct    = idle_by_phase[p];
            receiver_stall_pct = stall_by_phase[p];
            random_items       = 0;
            while (random_items < 18) begin
                if ($urandom_range(9) < 8)
                    send_name();
                else
                    send_noise();
            end
            in_ch.valid <= 1'b0;
            drain();
        end

        receiver_stall_pct = 0;
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_bytes_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
